// File: hdl/nvs_pkg.sv
// package: shared constants and operation codes for the nearest vertex search
`default_nettype none
package nvs_pkg;

   // default sizing
   localparam int MAX_VERTICES_DEF = 1024;
   localparam int COORD_BITS_DEF   = 24;

   // fixed field widths
   localparam int FUNC_BITS   = 2;
   localparam int STATUS_BITS = 2;

   // operation codes carried in func
   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_APPEND = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_QUERY  = 2'd2;

   // result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

endpackage
`default_nettype wire

// File: hdl/nvs_req_if.sv
// interface: request channel carrying one operation item
`default_nettype none
interface nvs_req_if
   import nvs_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [FUNC_BITS-1:0]  func;
   logic [COORD_BITS-1:0] point_x;
   logic [COORD_BITS-1:0] point_y;

   modport source (output valid, output func, output point_x, output point_y, input ready);
   modport sink   (input valid, input func, input point_x, input point_y, output ready);
endinterface
`default_nettype wire

// File: hdl/nvs_rsp_if.sv
// interface: response channel carrying one result item
`default_nettype none
interface nvs_rsp_if
   import nvs_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int IDX_BITS   = $clog2(MAX_VERTICES_DEF)
);
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [IDX_BITS-1:0]    nearest_index;
   logic [COORD_BITS-1:0]  nearest_x;
   logic [COORD_BITS-1:0]  nearest_y;

   modport source (output valid, output status, output nearest_index, output nearest_x,
                   output nearest_y, input ready);
   modport sink   (input valid, input status, input nearest_index, input nearest_x,
                   input nearest_y, output ready);
endinterface
`default_nettype wire

// File: hdl/nearest_vertex_search.sv
// top level: vertex table with linear nearest-vertex scan
//
// usage
//   req_chan takes one item per handshake: func selects clear, append or query,
//   point_x/point_y give the vertex or query point (signed, 8 fraction bits).
//   rsp_chan returns exactly one item per request, in request order.
// sequencing
//   clear, append and unused codes: the result is held as pending, then moves
//   to the output register when it is free. a query reads every stored vertex;
//   the vertex memory is read once per cycle through its single read port,
//   followed by a three-stage distance pipeline (abs diff, square, compare).
//   a new item is accepted the cycle after the previous result is registered.
// reset
//   synchronous; empties the table (count to zero) and drops any pending item.
//   memory contents are not cleared; only entries below the count are read.
// stall
//   the result waits in the output register while rsp_chan.ready is low; the
//   next item may be accepted and worked on, and its result is held until the
//   output register frees up.
`default_nettype none
module nearest_vertex_search
   import nvs_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int COORD_BITS   = COORD_BITS_DEF
) (
   input  wire        clock,
   input  wire        reset,
   nvs_req_if.sink    req_chan,
   nvs_rsp_if.source  rsp_chan
);

   localparam int IDX_BITS  = $clog2(MAX_VERTICES);
   localparam int CNT_BITS  = $clog2(MAX_VERTICES + 1);
   localparam int DIST_BITS = 2 * COORD_BITS + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HOLD
   } state_type;

   state_type state_ff;

   // vertex memory, x in the upper half
   logic [2*COORD_BITS-1:0] vertex_mem [MAX_VERTICES];

   logic [CNT_BITS-1:0]    count_ff;
   logic [IDX_BITS-1:0]    addr_ff;
   logic                   issue_ff;
   logic [COORD_BITS-1:0]  qx_ff;
   logic [COORD_BITS-1:0]  qy_ff;

   // pending result
   logic [STATUS_BITS-1:0] res_status_ff;
   logic [IDX_BITS-1:0]    res_idx_ff;
   logic [COORD_BITS-1:0]  res_x_ff;
   logic [COORD_BITS-1:0]  res_y_ff;

   // output register
   logic                   rsp_valid_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [IDX_BITS-1:0]    rsp_idx_ff;
   logic [COORD_BITS-1:0]  rsp_x_ff;
   logic [COORD_BITS-1:0]  rsp_y_ff;

   // running best
   logic                   first_ff;
   logic [DIST_BITS-1:0]   best_dist_ff;
   logic [IDX_BITS-1:0]    best_idx_ff;
   logic [COORD_BITS-1:0]  best_x_ff;
   logic [COORD_BITS-1:0]  best_y_ff;

   // read stage
   logic                    rd_valid_ff;
   logic                    rd_last_ff;
   logic [IDX_BITS-1:0]     rd_idx_ff;
   logic [2*COORD_BITS-1:0] rd_data_ff;

   // abs diff stage
   logic                   s1_valid_ff;
   logic                   s1_last_ff;
   logic [IDX_BITS-1:0]    s1_idx_ff;
   logic [COORD_BITS-1:0]  s1_x_ff;
   logic [COORD_BITS-1:0]  s1_y_ff;
   logic [COORD_BITS-1:0]  ad_x_ff;
   logic [COORD_BITS-1:0]  ad_y_ff;

   // square stage
   logic                    s2_valid_ff;
   logic                    s2_last_ff;
   logic [IDX_BITS-1:0]     s2_idx_ff;
   logic [COORD_BITS-1:0]   s2_x_ff;
   logic [COORD_BITS-1:0]   s2_y_ff;
   logic [2*COORD_BITS-1:0] sq_x_ff;
   logic [2*COORD_BITS-1:0] sq_y_ff;

   logic                   req_fire;
   logic                   rsp_free;
   logic                   wr_en;
   logic                   rd_en;
   logic                   table_full;
   logic [IDX_BITS-1:0]    last_idx;
   logic [COORD_BITS:0]    diff_x;
   logic [COORD_BITS:0]    diff_y;
   logic [COORD_BITS:0]    mag_x_in;
   logic [COORD_BITS:0]    mag_y_in;
   logic [2*COORD_BITS-1:0] sq_x_in;
   logic [2*COORD_BITS-1:0] sq_y_in;
   logic [DIST_BITS-1:0]   dist_in;
   logic                   take_in;
   logic [DIST_BITS-1:0]   win_dist_in;
   logic [IDX_BITS-1:0]    win_idx_in;
   logic [COORD_BITS-1:0]  win_x_in;
   logic [COORD_BITS-1:0]  win_y_in;

   // handshake and control decode
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && (state_ff == ST_IDLE);
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign table_full     = (count_ff == CNT_BITS'(MAX_VERTICES));
   assign wr_en          = req_fire && (req_chan.func == FUNC_APPEND) && !table_full;
   assign rd_en          = (state_ff == ST_SCAN) && issue_ff;
   assign last_idx       = IDX_BITS'(count_ff - CNT_BITS'(1));

   // vertex memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         vertex_mem[count_ff[IDX_BITS-1:0]] <= {req_chan.point_x, req_chan.point_y};
      end
      if (rd_en) begin
         rd_data_ff <= vertex_mem[addr_ff];
      end
   end

   // absolute coordinate differences against the query point
   assign diff_x   = {rd_data_ff[2*COORD_BITS-1], rd_data_ff[2*COORD_BITS-1:COORD_BITS]}
                   - {qx_ff[COORD_BITS-1], qx_ff};
   assign diff_y   = {rd_data_ff[COORD_BITS-1], rd_data_ff[COORD_BITS-1:0]}
                   - {qy_ff[COORD_BITS-1], qy_ff};
   assign mag_x_in = diff_x[COORD_BITS] ? (~diff_x + 1'b1) : diff_x;
   assign mag_y_in = diff_y[COORD_BITS] ? (~diff_y + 1'b1) : diff_y;

   // squares and distance sum
   assign sq_x_in = ad_x_ff * ad_x_ff;
   assign sq_y_in = ad_y_ff * ad_y_ff;
   assign dist_in = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};

   // best selection, later vertex wins on a tie
   assign take_in     = first_ff || (dist_in <= best_dist_ff);
   assign win_dist_in = take_in ? dist_in   : best_dist_ff;
   assign win_idx_in  = take_in ? s2_idx_ff : best_idx_ff;
   assign win_x_in    = take_in ? s2_x_ff   : best_x_ff;
   assign win_y_in    = take_in ? s2_y_ff   : best_y_ff;

   // distance pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
         s1_valid_ff <= rd_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
      rd_last_ff <= (addr_ff == last_idx);
      rd_idx_ff  <= addr_ff;
      s1_last_ff <= rd_last_ff;
      s1_idx_ff  <= rd_idx_ff;
      s1_x_ff    <= rd_data_ff[2*COORD_BITS-1:COORD_BITS];
      s1_y_ff    <= rd_data_ff[COORD_BITS-1:0];
      ad_x_ff    <= mag_x_in[COORD_BITS-1:0];
      ad_y_ff    <= mag_y_in[COORD_BITS-1:0];
      s2_last_ff <= s1_last_ff;
      s2_idx_ff  <= s1_idx_ff;
      s2_x_ff    <= s1_x_ff;
      s2_y_ff    <= s1_y_ff;
      sq_x_ff    <= sq_x_in;
      sq_y_ff    <= sq_y_in;
   end

   // sequencer, table count and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  res_status_ff <= STATUS_OK;
                  res_idx_ff    <= '0;
                  res_x_ff      <= '0;
                  res_y_ff      <= '0;
                  qx_ff         <= req_chan.point_x;
                  qy_ff         <= req_chan.point_y;
                  state_ff      <= ST_HOLD;
                  case (req_chan.func)
                     FUNC_CLEAR: begin
                        count_ff <= '0;
                     end
                     FUNC_APPEND: begin
                        if (table_full) begin
                           res_status_ff <= STATUS_FULL;
                        end else begin
                           res_idx_ff <= count_ff[IDX_BITS-1:0];
                           count_ff   <= count_ff + CNT_BITS'(1);
                        end
                     end
                     FUNC_QUERY: begin
                        if (count_ff == '0) begin
                           res_status_ff <= STATUS_EMPTY;
                        end else begin
                           state_ff <= ST_SCAN;
                           issue_ff <= 1'b1;
                           addr_ff  <= '0;
                           first_ff <= 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (issue_ff) begin
                  addr_ff <= addr_ff + IDX_BITS'(1);
                  if (addr_ff == last_idx) begin
                     issue_ff <= 1'b0;
                  end
               end
               if (s2_valid_ff) begin
                  first_ff     <= 1'b0;
                  best_dist_ff <= win_dist_in;
                  best_idx_ff  <= win_idx_in;
                  best_x_ff    <= win_x_in;
                  best_y_ff    <= win_y_in;
                  if (s2_last_ff) begin
                     res_idx_ff <= win_idx_in;
                     res_x_ff   <= win_x_in;
                     res_y_ff   <= win_y_in;
                     state_ff   <= ST_HOLD;
                  end
               end
            end
            ST_HOLD: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_idx_ff    <= res_idx_ff;
                  rsp_x_ff      <= res_x_ff;
                  rsp_y_ff      <= res_y_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // response channel drive
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.nearest_index = rsp_idx_ff;
   assign rsp_chan.nearest_x     = rsp_x_ff;
   assign rsp_chan.nearest_y     = rsp_y_ff;

`ifndef SYNTHESIS
   // no table write may land while a scan is reading the memory
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !wr_en)
      else $error("vertex write during scan");

   // count stays within the table depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_VERTICES))
      else $error("vertex count beyond table depth");

   // a clear item empties the table
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_chan.func == FUNC_CLEAR)) |=> (count_ff == '0))
      else $error("clear did not empty the table");

   // pipeline work only happens inside a scan
   assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (state_ff == ST_SCAN))
      else $error("distance stage active outside scan");
`endif

endmodule
`default_nettype wire

// File: bench/tb_nearest_vertex_search.sv
// testbench: random and directed checking of the nearest vertex search against a vertex table tracker
`default_nettype none
module tb_nearest_vertex_search;
   import nvs_pkg::*;

   localparam int COORD_W     = COORD_BITS_DEF;
   localparam int IDX_W       = $clog2(MAX_VERTICES_DEF);
   localparam int RANDOM_ITEMS = 560;
   localparam int STALL_LIMIT = 6000;
   localparam int HOLD_CYCLES = 300;

   // func code the block ignores
   localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;

   localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [IDX_W-1:0]       index;
      logic [COORD_W-1:0]     x;
      logic [COORD_W-1:0]     y;
   } search_result_t;

   // vertex table tracker: predicts each result and holds the ones still due
   class vertex_search_tracker;
      logic signed [COORD_W-1:0] vert_x [MAX_VERTICES_DEF];
      logic signed [COORD_W-1:0] vert_y [MAX_VERTICES_DEF];
      int unsigned    stored;
      search_result_t awaited [$];
      int unsigned    mismatches;

      function void note_request(logic [FUNC_BITS-1:0] func,
                                 logic signed [COORD_W-1:0] px,
                                 logic signed [COORD_W-1:0] py);
         search_result_t r;
         longint dx, dy, sq_sum, best_dist;
         int unsigned best;
         r = '0;
         case (func)
            FUNC_CLEAR: begin
               stored = 0;
            end
            FUNC_APPEND: begin
               if (stored >= MAX_VERTICES_DEF) begin
                  r.status = STATUS_FULL;
               end else begin
                  vert_x[stored] = px;
                  vert_y[stored] = py;
                  r.index = IDX_W'(stored);
                  stored++;
               end
            end
            FUNC_QUERY: begin
               if (stored == 0) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  best = 0;
                  best_dist = -1;
                  // exact squared distance, later vertex wins a tie
                  for (int j = 0; j < stored; j++) begin
                     dx = longint'(vert_x[j]) - longint'(px);
                     dy = longint'(vert_y[j]) - longint'(py);
                     sq_sum = dx * dx + dy * dy;
                     if (best_dist < 0 || sq_sum <= best_dist) begin
                        best_dist = sq_sum;
                        best = j;
                     end
                  end
                  r.index = IDX_W'(best);
                  r.x = vert_x[best];
                  r.y = vert_y[best];
               end
            end
            default: ;
         endcase
         awaited = {awaited, r};
      endfunction

      function void compare_field(string field, logic [COORD_W-1:0] want,
                                  logic [COORD_W-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(search_result_t got);
         search_result_t want;
         if (awaited.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, got %0h", $time, got);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         compare_field("status", COORD_W'(want.status), COORD_W'(got.status));
         compare_field("nearest_index", COORD_W'(want.index), COORD_W'(got.index));
         compare_field("nearest_x", want.x, got.x);
         compare_field("nearest_y", want.y, got.y);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   steady_flow = 1'b0;

   vertex_search_tracker tracker = new();

   nvs_req_if req_chan ();
   nvs_rsp_if rsp_chan ();

   nearest_vertex_search dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // coordinate mix: extremes, small values near zero, full range
   function automatic logic [COORD_W-1:0] rand_coord();
      case ($urandom_range(9))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return COORD_W'(int'($urandom_range(2047)) - 1024);
         default: return COORD_W'($urandom);
      endcase
   endfunction

   // small step on a one-unit grid, so clustered points often tie
   function automatic logic [COORD_W-1:0] grid_offset();
      return COORD_W'((int'($urandom_range(4)) - 2) * 256);
   endfunction

   // offer one item and wait for it to be taken
   task automatic send_item(input logic [FUNC_BITS-1:0] func,
                            input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
      while (!steady_flow && $urandom_range(99) < 23) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.func    <= func;
      req_chan.point_x <= px;
      req_chan.point_y <= py;
      do @(posedge clock); while (!req_chan.ready);
      tracker.note_request(func, px, py);
   endtask

   // stop offering until every expected result is back
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (tracker.awaited.size() != 0);
   endtask

   // result side: check accepted items, random and long stalls
   initial begin
      int unsigned hold_left;
      int unsigned seen;
      search_result_t got;
      hold_left = 0;
      seen = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.status = rsp_chan.status;
            got.index  = rsp_chan.nearest_index;
            got.x      = rsp_chan.nearest_x;
            got.y      = rsp_chan.nearest_y;
            tracker.check_result(got);
            seen++;
            if (seen == 40 || seen == 400) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (steady_flow) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= 23);
         end
      end
   end

   // watchdog on cycles with no item moving
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("[nearest_vertex_search] ERROR");
      $finish;
   end

   // stimulus
   initial begin
      int unsigned issued, run_len, n_query, pick, j;
      logic [FUNC_BITS-1:0] f;
      logic [COORD_W-1:0] cx, cy, px, py;
      bit clustered;

      req_chan.valid   <= 1'b0;
      req_chan.func    <= FUNC_CLEAR;
      req_chan.point_x <= '0;
      req_chan.point_y <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty query, corners, ties, ignored code, clear
      send_item(FUNC_QUERY, '0, '0);
      send_item(FUNC_APPEND, COORD_MAX, COORD_MAX);
      send_item(FUNC_APPEND, COORD_MIN, COORD_MIN);
      send_item(FUNC_QUERY, COORD_MIN, COORD_MIN);
      send_item(FUNC_QUERY, COORD_MAX, COORD_MAX);
      send_item(FUNC_APPEND, COORD_MIN, COORD_MAX);
      send_item(FUNC_APPEND, COORD_MAX, COORD_MIN);
      send_item(FUNC_QUERY, '0, '0);
      send_item(FUNC_APPEND, COORD_MIN, COORD_MIN);
      send_item(FUNC_QUERY, COORD_MIN, COORD_MIN);
      send_item(FUNC_UNUSED, COORD_MAX, COORD_MIN);
      send_item(FUNC_QUERY, COORD_MAX, COORD_MIN);
      send_item(FUNC_CLEAR, COORD_MAX, COORD_MAX);
      send_item(FUNC_QUERY, COORD_MIN, COORD_MAX);
      send_item(FUNC_APPEND, COORD_W'(256), '0);
      send_item(FUNC_APPEND, COORD_W'(-256), '0);
      send_item(FUNC_QUERY, '0, '0);
      send_item(FUNC_CLEAR, '0, '0);
      wait_drained();

      // random: mostly clear, append run, queries; some noise and pauses
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         steady_flow = (issued >= 250 && issued < 350);
         pick = $urandom_range(99);
         if (pick < 72) begin
            if ($urandom_range(3) != 0) begin
               send_item(FUNC_CLEAR, rand_coord(), rand_coord());
               issued++;
            end
            run_len = ($urandom_range(9) == 0) ? $urandom_range(150, 30) : $urandom_range(12, 1);
            cx = rand_coord();
            cy = rand_coord();
            clustered = ($urandom_range(1) != 0);
            for (int k = 0; k < run_len; k++) begin
               if (clustered) begin
                  px = cx + grid_offset();
                  py = cy + grid_offset();
               end else begin
                  px = rand_coord();
                  py = rand_coord();
               end
               send_item(FUNC_APPEND, px, py);
               issued++;
            end
            n_query = $urandom_range(5, 1);
            for (int k = 0; k < n_query; k++) begin
               case ($urandom_range(2))
                  0: begin
                     px = cx + grid_offset();
                     py = cy + grid_offset();
                  end
                  1: begin
                     if (tracker.stored > 0) begin
                        j = $urandom_range(tracker.stored - 1);
                        px = tracker.vert_x[j];
                        py = tracker.vert_y[j];
                     end else begin
                        px = rand_coord();
                        py = rand_coord();
                     end
                  end
                  default: begin
                     px = rand_coord();
                     py = rand_coord();
                  end
               endcase
               send_item(FUNC_QUERY, px, py);
               issued++;
            end
         end else if (pick < 97) begin
            f = FUNC_BITS'($urandom_range(3));
            send_item(f, rand_coord(), rand_coord());
            if (f != FUNC_UNUSED) issued++;
         end else begin
            wait_drained();
         end
      end
      steady_flow = 1'b0;

      wait_drained();
      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
         $display("[nearest_vertex_search] OK");
      end else begin
         $display("[nearest_vertex_search] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: sim.f
hdl/nvs_pkg.sv
hdl/nvs_req_if.sv
hdl/nvs_rsp_if.sv
hdl/nearest_vertex_search.sv
bench/tb_nearest_vertex_search.sv
